// ===== hdl/utf8d_pkg.sv =====
// constants, codes and helpers shared by the utf-8 decoder files
package utf8d_pkg;

  localparam int HISTORY_DEPTH = 16;

  localparam int OP_W   = 2;
  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;
  localparam int LEN_W  = 3;
  localparam int ST_W   = 3;

  // ring index and fill count widths
  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_DATA  = 2'd0;
  localparam logic [OP_W-1:0] OP_UNGET = 2'd1;
  localparam logic [OP_W-1:0] OP_TAKE  = 2'd2;
  localparam logic [OP_W-1:0] OP_END   = 2'd3;

  localparam logic [ST_W-1:0] ST_DECODED  = 3'd0;
  localparam logic [ST_W-1:0] ST_REPLAYED = 3'd1;
  localparam logic [ST_W-1:0] ST_BADCONT  = 3'd2;
  localparam logic [ST_W-1:0] ST_BADLEAD  = 3'd3;
  localparam logic [ST_W-1:0] ST_TRUNC    = 3'd4;
  localparam logic [ST_W-1:0] ST_END      = 3'd5;
  localparam logic [ST_W-1:0] ST_NONE     = 3'd6;

  // encoded length from the value range
  function automatic logic [LEN_W-1:0] len_of(input logic [CP_W-1:0] cp);
    logic [LEN_W-1:0] len;
    if (cp < CP_W'(32'h80)) len = 3'd1;
    else if (cp < CP_W'(32'h800)) len = 3'd2;
    else if (cp < CP_W'(32'h10000)) len = 3'd3;
    else len = 3'd4;
    return len;
  endfunction

endpackage

// ===== hdl/utf8d_in_if.sv =====
// input channel: opcode and raw byte
interface utf8d_in_if;
  import utf8d_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [BYTE_W-1:0] byte_value;

  modport source (output valid, output opcode, output byte_value, input ready);
  modport sink   (input valid, input opcode, input byte_value, output ready);
endinterface

// ===== hdl/utf8d_out_if.sv =====
// result channel: code point, length and status
interface utf8d_out_if;
  import utf8d_pkg::*;

  logic             valid;
  logic             ready;
  logic [CP_W-1:0]  code_point;
  logic [LEN_W-1:0] byte_count;
  logic [ST_W-1:0]  status;

  modport source (output valid, output code_point, output byte_count, output status,
                  input ready);
  modport sink   (input valid, input code_point, input byte_count, input status,
                  output ready);
endinterface

// ===== hdl/utf8_decoder_with_pushback_core.sv =====
// utf-8 decoder with a replay history ring, top level
//
//  channel  dir  handshake      payload
//  cmd      in   valid/ready    opcode[1:0], byte_value[7:0]
//  res      out  valid/ready    code_point[20:0], byte_count[2:0], status[2:0]
//
// one item is accepted per cycle while cmd.ready is high; decoder and ring state update at acceptance
// a result reaches res through the middle stage and the result register: the ring read
// is registered with the middle stage, then the result register is loaded
// cmd.ready drops only while both the middle stage and the result register are full
// and res is stalled; rst (synchronous) empties both stages and clears decoder and history state
// but not the ring, whose entries are read only after they have been written
module utf8_decoder_with_pushback_core (
  input logic clk,
  input logic rst,
  utf8d_in_if.sink cmd,
  utf8d_out_if.source res
);
  import utf8d_pkg::*;

  localparam int SW = CNT_W + 1;

  // decoder and history state
  logic [CP_W-1:0]  partial_value, partial_value_next;
  logic [1:0]       bytes_remaining, bytes_remaining_next;
  logic [LEN_W-1:0] sequence_length, sequence_length_next;
  logic [IDX_W-1:0] write_index, write_index_next;
  logic [CNT_W-1:0] entries_held, entries_held_next;
  logic [CNT_W-1:0] pending_replays, pending_replays_next;

  logic [CP_W-1:0] ring [HISTORY_DEPTH];
  logic [CP_W-1:0] rd_data;
  logic [IDX_W-1:0] raddr;

  // per-item result before the ring read lands
  logic             r_valid, r_replay;
  logic [CP_W-1:0]  r_cp;
  logic [LEN_W-1:0] r_len;
  logic [ST_W-1:0]  r_status;
  logic             store;
  logic [CP_W-1:0]  store_cp;

  // middle stage
  logic             s1_valid, s1_replay;
  logic [CP_W-1:0]  s1_cp;
  logic [LEN_W-1:0] s1_len;
  logic [ST_W-1:0]  s1_status;

  // result register
  logic             out_valid;
  logic [CP_W-1:0]  out_cp;
  logic [LEN_W-1:0] out_len;
  logic [ST_W-1:0]  out_status;

  logic accept, s1_adv;

  assign s1_adv    = s1_valid && (!out_valid || res.ready);
  assign cmd.ready = !s1_valid || s1_adv;
  assign accept    = cmd.valid && cmd.ready;

  // oldest pending entry sits pending_replays places behind write_index
  always_comb begin
    logic [SW-1:0] rsum;
    rsum = SW'(write_index) + SW'(HISTORY_DEPTH) - SW'(pending_replays);
    if (rsum >= SW'(HISTORY_DEPTH)) rsum = rsum - SW'(HISTORY_DEPTH);
    raddr = rsum[IDX_W-1:0];
  end

  always_comb begin
    logic [BYTE_W-1:0] b;
    logic [CP_W-1:0]   pv;
    b  = cmd.byte_value;
    pv = {partial_value[CP_W-7:0], b[5:0]};

    partial_value_next   = partial_value;
    bytes_remaining_next = bytes_remaining;
    sequence_length_next = sequence_length;
    pending_replays_next = pending_replays;
    r_valid  = 1'b0;
    r_replay = 1'b0;
    r_cp     = '0;
    r_len    = '0;
    r_status = ST_DECODED;
    store    = 1'b0;
    store_cp = '0;

    case (cmd.opcode)
      OP_UNGET: begin
        if (pending_replays < entries_held) pending_replays_next = pending_replays + 1'b1;
      end
      OP_TAKE: begin
        r_valid = 1'b1;
        if (pending_replays == '0) begin
          r_status = ST_NONE;
        end else begin
          r_status = ST_REPLAYED;
          r_replay = 1'b1;
          pending_replays_next = pending_replays - 1'b1;
        end
      end
      OP_END: begin
        r_valid = 1'b1;
        if (bytes_remaining != 2'd0) begin
          partial_value_next   = '0;
          bytes_remaining_next = 2'd0;
          sequence_length_next = '0;
          r_status = ST_TRUNC;
        end else begin
          r_status = ST_END;
        end
      end
      OP_DATA: begin
        if (bytes_remaining == 2'd0) begin
          if (!b[7]) begin
            store    = 1'b1;
            store_cp = CP_W'(b);
            r_valid  = 1'b1;
            r_cp     = CP_W'(b);
            r_len    = 3'd1;
          end else if (b[7:5] == 3'b110) begin
            partial_value_next   = CP_W'(b[4:0]);
            bytes_remaining_next = 2'd1;
            sequence_length_next = 3'd2;
          end else if (b[7:4] == 4'b1110) begin
            partial_value_next   = CP_W'(b[3:0]);
            bytes_remaining_next = 2'd2;
            sequence_length_next = 3'd3;
          end else if (b[7:3] == 5'b11110) begin
            partial_value_next   = CP_W'(b[2:0]);
            bytes_remaining_next = 2'd3;
            sequence_length_next = 3'd4;
          end else begin
            r_valid  = 1'b1;
            r_status = ST_BADLEAD;
          end
        end else if (b[7:6] != 2'b10) begin
          partial_value_next   = '0;
          bytes_remaining_next = 2'd0;
          sequence_length_next = '0;
          r_valid  = 1'b1;
          r_status = ST_BADCONT;
        end else if (bytes_remaining == 2'd1) begin
          // last continuation closes the sequence
          partial_value_next   = '0;
          bytes_remaining_next = 2'd0;
          sequence_length_next = '0;
          store    = 1'b1;
          store_cp = pv;
          r_valid  = 1'b1;
          r_cp     = pv;
          r_len    = sequence_length;
        end else begin
          partial_value_next   = pv;
          bytes_remaining_next = bytes_remaining - 2'd1;
        end
      end
      default: begin
      end
    endcase

    write_index_next  = write_index;
    entries_held_next = entries_held;
    if (store) begin
      if (write_index == IDX_W'(HISTORY_DEPTH - 1)) write_index_next = '0;
      else write_index_next = write_index + 1'b1;
      if (entries_held < CNT_W'(HISTORY_DEPTH)) entries_held_next = entries_held + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value   <= '0;
      bytes_remaining <= 2'd0;
      sequence_length <= '0;
      write_index     <= '0;
      entries_held    <= '0;
      pending_replays <= '0;
    end else if (accept) begin
      partial_value   <= partial_value_next;
      bytes_remaining <= bytes_remaining_next;
      sequence_length <= sequence_length_next;
      write_index     <= write_index_next;
      entries_held    <= entries_held_next;
      pending_replays <= pending_replays_next;
    end
  end

  // history ring: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (accept && store) ring[write_index] <= store_cp;
    if (accept && r_replay) rd_data <= ring[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= r_valid;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_replay <= r_replay;
      s1_cp     <= r_cp;
      s1_len    <= r_len;
      s1_status <= r_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status <= s1_status;
      if (s1_replay) begin
        out_cp  <= rd_data;
        out_len <= len_of(rd_data);
      end else begin
        out_cp  <= s1_cp;
        out_len <= s1_len;
      end
    end
  end

  assign res.valid      = out_valid;
  assign res.code_point = out_cp;
  assign res.byte_count = out_len;
  assign res.status     = out_status;

  a_pending_within_held: assert property (@(posedge clk) disable iff (rst)
    pending_replays <= entries_held)
    else $error("pending replay count above ring fill");

  a_held_bounded: assert property (@(posedge clk) disable iff (rst)
    entries_held <= CNT_W'(HISTORY_DEPTH))
    else $error("ring fill above depth");

  a_replay_has_length: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == ST_REPLAYED) |-> (out_len != '0))
    else $error("replayed item without a length");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> cmd.ready)
    else $error("input stalled with an empty middle stage");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res.ready) |=> (out_valid && $stable(out_cp) && $stable(out_status)))
    else $error("stalled result changed");

endmodule
